// ===== sv/lavm_pkg.sv =====
`timescale 1ns / 1ps
// lavm_pkg: shared types and constants for the look-at view matrix block.
// No dependencies; every other file imports it.
package lavm_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // job queue between the front and back parts
    localparam int QDEPTH = 4;
    localparam int QAW    = 2;
    localparam logic [QAW:0] QFULL = QDEPTH[QAW:0];

    typedef struct packed {
        logic signed [31:0] cam_x;
        logic signed [31:0] cam_y;
        logic signed [31:0] cam_z;
        logic signed [31:0] target_x;
        logic signed [31:0] target_y;
        logic signed [31:0] target_z;
    } t_in;

    typedef struct packed {
        logic [1:0]         column_index;
        logic signed [31:0] elem0;
        logic signed [31:0] elem1;
        logic signed [31:0] elem2;
        logic signed [31:0] elem3;
        logic               degenerate;
        logic               last_column;
    } t_out;

    // camera position and position - target, both indexed x, y, z
    typedef struct packed {
        logic [2:0][31:0] pos;
        logic [2:0][32:0] dif;
    } t_job;

    typedef struct packed {
        logic             start;
        logic [2:0][63:0] vec;
    } t_norm_req;

    typedef struct packed {
        logic             done;
        logic             ok;
        logic [2:0][31:0] u;
    } t_norm_rsp;

    typedef enum logic [2:0] {
        N_IDLE,
        N_SHIFT,
        N_SQ,
        N_SQRT,
        N_DIV
    } t_nstate;

    typedef enum logic [3:0] {
        B_IDLE,
        B_NF,
        B_NR,
        B_CROSS,
        B_US,
        B_NU,
        B_DOT,
        B_FIN,
        B_HAND
    } t_bstate;

endpackage

// ===== sv/look_at_view_matrix_top.sv =====
`timescale 1ns / 1ps
// look_at_view_matrix_top: camera/target in, four view matrix columns out.
// Each normalization shifts, sums squares, takes a bit-serial square root and divides;
// an item takes three of them plus the cross and dot products and the hand-off.
// The front and a 4-deep job queue keep taking transactions while an item is worked on.
// Synchronous active-low reset empties the queue and idles the sequencers.
module look_at_view_matrix_top #(
    parameter int FRAC_BITS = lavm_pkg::FRAC_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_stall,
    input  lavm_pkg::t_in  i_in,
    output logic           o_valid,
    input  logic           i_stall,
    output lavm_pkg::t_out o_out
);
    import lavm_pkg::*;

    t_job w_fjob;
    t_job w_qjob;
    logic w_push;
    logic w_pop;
    logic w_empty;
    logic w_full;

    lavm_front u_front (
        .i_valid(i_valid),
        .i_in   (i_in),
        .i_full (w_full),
        .o_stall(o_stall),
        .o_push (w_push),
        .o_job  (w_fjob)
    );

    lavm_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (w_push),
        .i_job  (w_fjob),
        .i_pop  (w_pop),
        .o_job  (w_qjob),
        .o_empty(w_empty),
        .o_full (w_full)
    );

    lavm_back #(
        .FRAC_BITS(FRAC_BITS)
    ) u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_job  (w_qjob),
        .i_empty(w_empty),
        .o_pop  (w_pop),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_out  (o_out)
    );

    // columns leave in order 0, 1, 2, 3 without gaps inside one matrix
    a_col_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_stall && (o_out.column_index != 2'd3) |=>
        o_valid && (o_out.column_index == 2'($past(o_out.column_index) + 2'd1)))
        else $error("column sequence broken");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_out.degenerate && (o_out.column_index != 2'd3) |->
        (o_out.elem0 == '0) && (o_out.elem1 == '0) && (o_out.elem2 == '0) &&
        (o_out.elem3 == '0))
        else $error("degenerate column not zero");

    a_queue_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty && $past(i_rst_n))
        else $error("pop from empty job queue");

endmodule

// ===== sv/lavm_front.sv =====
`timescale 1ns / 1ps
// lavm_front: accepts camera/target transactions and forms position - target.
// Depends on lavm_pkg.
module lavm_front (
    input  logic           i_valid,
    input  lavm_pkg::t_in  i_in,
    input  logic           i_full,
    output logic           o_stall,
    output logic           o_push,
    output lavm_pkg::t_job o_job
);
    import lavm_pkg::*;

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    always_comb begin
        o_job.pos[0] = i_in.cam_x;
        o_job.pos[1] = i_in.cam_y;
        o_job.pos[2] = i_in.cam_z;
        // 33 bits so the difference never wraps
        o_job.dif[0] = 33'(i_in.cam_x) - 33'(i_in.target_x);
        o_job.dif[1] = 33'(i_in.cam_y) - 33'(i_in.target_y);
        o_job.dif[2] = 33'(i_in.cam_z) - 33'(i_in.target_z);
    end

endmodule

// ===== sv/lavm_fifo.sv =====
`timescale 1ns / 1ps
// lavm_fifo: short job queue that decouples the front from the back.
// Depends on lavm_pkg.
module lavm_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  lavm_pkg::t_job i_job,
    input  logic           i_pop,
    output lavm_pkg::t_job o_job,
    output logic           o_empty,
    output logic           o_full
);
    import lavm_pkg::*;

    t_job           r_mem [QDEPTH];
    logic [QAW-1:0] r_wp;
    logic [QAW-1:0] r_rp;
    logic [QAW:0]   r_cnt;

    assign o_job   = r_mem[r_rp];
    assign o_empty = (r_cnt == '0);
    assign o_full  = (r_cnt == QFULL);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= r_wp + 1'b1;
            if (i_pop)  r_rp <= r_rp + 1'b1;
            if (i_push && !i_pop)      r_cnt <= r_cnt + 1'b1;
            else if (!i_push && i_pop) r_cnt <= r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_job;
    end

endmodule

// ===== sv/lavm_norm.sv =====
`timescale 1ns / 1ps
// lavm_norm: 3-vector normalizer; bit-serial shift, squared sum, square root
// and three restoring dividers. Depends on lavm_pkg.
module lavm_norm #(
    parameter int FRAC_BITS = lavm_pkg::FRAC_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  lavm_pkg::t_norm_req i_req,
    output lavm_pkg::t_norm_rsp o_rsp
);
    import lavm_pkg::*;

    localparam int QW  = FRAC_BITS + 2;
    localparam int QCW = $clog2(QW);

    t_nstate          r_state, n_state;
    logic             r_done, n_done;
    logic             r_ok, n_ok;
    logic [2:0][63:0] r_mg, n_mg;
    logic [2:0]       r_ng, n_ng;
    logic [63:0]      r_m, n_m;
    logic [63:0]      r_sum, n_sum;
    logic [63:0]      r_res, n_res;
    logic [63:0]      r_prod, n_prod;
    logic [63:0]      r_dvs, n_dvs;
    logic [2:0][63:0] r_rem, n_rem;
    logic [2:0][QW-1:0] r_q, n_q;
    logic [2:0][31:0] r_u, n_u;
    logic [1:0]       r_cnt, n_cnt;
    logic [4:0]       r_k, n_k;
    logic [QCW-1:0]   r_qc, n_qc;

    logic [2:0][63:0] w_mg;
    logic [2:0]       w_ng;
    logic [63:0]      w_m;
    logic [63:0]      w_bit;
    logic [63:0]      w_trial;
    logic [31:0]      w_sqop;
    logic [63:0]      w_sq;

    always_comb begin
        w_m = '0;
        for (int i = 0; i < 3; i++) begin
            w_ng[i] = i_req.vec[i][63];
            w_mg[i] = w_ng[i] ? -i_req.vec[i] : i_req.vec[i];
            if (w_mg[i] > w_m) w_m = w_mg[i];
        end
        w_bit   = 64'd1 << {r_k, 1'b0};
        w_trial = r_res + w_bit;
        case (r_cnt)
            2'd0:    w_sqop = r_mg[0][31:0];
            2'd1:    w_sqop = r_mg[1][31:0];
            2'd2:    w_sqop = r_mg[2][31:0];
            default: w_sqop = '0;
        endcase
        w_sq = 64'(w_sqop) * 64'(w_sqop);
    end

    always_comb begin
        n_state = r_state;
        n_done  = 1'b0;
        n_ok    = r_ok;
        n_mg    = r_mg;
        n_ng    = r_ng;
        n_m     = r_m;
        n_sum   = r_sum;
        n_res   = r_res;
        n_prod  = r_prod;
        n_dvs   = r_dvs;
        n_rem   = r_rem;
        n_q     = r_q;
        n_u     = r_u;
        n_cnt   = r_cnt;
        n_k     = r_k;
        n_qc    = r_qc;
        case (r_state)
            N_IDLE: begin
                if (i_req.start) begin
                    n_ng  = w_ng;
                    n_mg  = w_mg;
                    n_m   = w_m;
                    n_sum = '0;
                    n_cnt = '0;
                    if (w_m == '0) begin
                        n_ok   = 1'b0;
                        n_u    = '0;
                        n_done = 1'b1;
                    end else begin
                        n_state = N_SHIFT;
                    end
                end
            end
            N_SHIFT: begin
                // bring the largest magnitude into [2^29, 2^30)
                if (r_m[63:30] != '0) begin
                    for (int i = 0; i < 3; i++) n_mg[i] = r_mg[i] >> 1;
                    n_m = r_m >> 1;
                end else if (r_m[63:29] == '0) begin
                    for (int i = 0; i < 3; i++) n_mg[i] = r_mg[i] << 1;
                    n_m = r_m << 1;
                end else begin
                    n_state = N_SQ;
                end
            end
            N_SQ: begin
                n_cnt  = r_cnt + 1'b1;
                n_prod = w_sq;
                if (r_cnt != 2'd0) n_sum = r_sum + r_prod;
                if (r_cnt == 2'd3) begin
                    n_state = N_SQRT;
                    n_k     = 5'd31;
                    n_res   = '0;
                end
            end
            N_SQRT: begin
                if (r_sum >= w_trial) begin
                    n_sum = r_sum - w_trial;
                    n_res = (r_res >> 1) + w_bit;
                end else begin
                    n_res = r_res >> 1;
                end
                if (r_k == '0) begin
                    n_state = N_DIV;
                    for (int i = 0; i < 3; i++)
                        n_rem[i] = (r_mg[i] << FRAC_BITS) + (n_res >> 1);
                    n_dvs = n_res << (QW - 1);
                    n_q   = '0;
                    n_qc  = QCW'(QW - 1);
                end else begin
                    n_k = r_k - 1'b1;
                end
            end
            N_DIV: begin
                for (int i = 0; i < 3; i++) begin
                    if (r_rem[i] >= r_dvs) begin
                        n_rem[i] = r_rem[i] - r_dvs;
                        n_q[i]   = {r_q[i][QW-2:0], 1'b1};
                    end else begin
                        n_q[i]   = {r_q[i][QW-2:0], 1'b0};
                    end
                end
                n_dvs = r_dvs >> 1;
                if (r_qc == '0) begin
                    n_state = N_IDLE;
                    n_ok    = 1'b1;
                    n_done  = 1'b1;
                    for (int i = 0; i < 3; i++)
                        n_u[i] = r_ng[i] ? -32'(n_q[i]) : 32'(n_q[i]);
                end else begin
                    n_qc = r_qc - 1'b1;
                end
            end
            default: n_state = N_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= N_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok   <= n_ok;
        r_mg   <= n_mg;
        r_ng   <= n_ng;
        r_m    <= n_m;
        r_sum  <= n_sum;
        r_res  <= n_res;
        r_prod <= n_prod;
        r_dvs  <= n_dvs;
        r_rem  <= n_rem;
        r_q    <= n_q;
        r_u    <= n_u;
        r_cnt  <= n_cnt;
        r_k    <= n_k;
        r_qc   <= n_qc;
    end

    assign o_rsp.done = r_done;
    assign o_rsp.ok   = r_ok;
    assign o_rsp.u    = r_u;

endmodule

// ===== sv/lavm_back.sv =====
`timescale 1ns / 1ps
// lavm_back: job sequencer; runs the three normalizations, cross and dot
// products on a shared multiplier, and emits four columns. Uses lavm_norm, lavm_pkg.
module lavm_back #(
    parameter int FRAC_BITS = lavm_pkg::FRAC_BITS_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  lavm_pkg::t_job i_job,
    input  logic           i_empty,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_stall,
    output lavm_pkg::t_out o_out
);
    import lavm_pkg::*;

    t_bstate          r_state, n_state;
    logic [2:0][31:0] r_pos, n_pos;
    logic [2:0][31:0] r_fw, n_fw;
    logic [2:0][31:0] r_rt, n_rt;
    logic [2:0][31:0] r_up, n_up;
    logic             r_ok, n_ok;
    logic [2:0][63:0] r_uin, n_uin;
    logic [63:0]      r_prod, n_prod;
    logic [3:0]       r_s, n_s;
    logic [1:0]       r_ptag, n_ptag;
    logic             r_pv, n_pv;
    logic [2:0][63:0] r_dot, n_dot;
    logic [2:0][31:0] r_nd, n_nd;
    logic             r_ebusy, n_ebusy;
    logic [1:0]       r_ecol, n_ecol;
    logic             r_eok, n_eok;
    logic [2:0][3:0][31:0] r_ecv, n_ecv;

    t_norm_req          w_req;
    t_norm_rsp          w_rsp;
    logic signed [31:0] w_ma;
    logic signed [31:0] w_mb;
    logic signed [63:0] w_mul;
    logic [1:0]         w_col;
    logic [1:0]         w_j;

    function automatic logic [31:0] f_neg_dot(input logic [63:0] s);
        logic        resneg;
        logic [63:0] mag;
        logic [63:0] r;
        logic [31:0] res;
        resneg = !s[63] && (s != '0);
        mag    = s[63] ? -s : s;
        r      = (mag + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        if (resneg) res = (r > 64'h8000_0000) ? 32'h8000_0000 : -r[31:0];
        else        res = (r > 64'h7fff_ffff) ? 32'h7fff_ffff : r[31:0];
        return res;
    endfunction

    lavm_norm #(
        .FRAC_BITS(FRAC_BITS)
    ) u_norm (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_req),
        .o_rsp  (w_rsp)
    );

    assign o_pop = (r_state == B_IDLE) && !i_empty;

    // requests to the normalizer
    always_comb begin
        w_req.start = 1'b0;
        w_req.vec   = '0;
        case (r_state)
            B_IDLE: begin
                w_req.start = !i_empty;
                for (int i = 0; i < 3; i++)
                    w_req.vec[i] = {{31{i_job.dif[i][32]}}, i_job.dif[i]};
            end
            B_NF: begin
                // right = cross(world up, forward) = (fz, 0, -fx)
                w_req.start  = w_rsp.done;
                w_req.vec[0] = {{32{w_rsp.u[2][31]}}, w_rsp.u[2]};
                w_req.vec[2] = -{{32{w_rsp.u[0][31]}}, w_rsp.u[0]};
            end
            B_US: begin
                w_req.start = 1'b1;
                w_req.vec   = r_uin;
            end
            default: ;
        endcase
    end

    // shared multiplier operand selection
    always_comb begin
        case (r_s)
            4'd0:    begin w_col = 2'd0; w_j = 2'd0; end
            4'd1:    begin w_col = 2'd0; w_j = 2'd1; end
            4'd2:    begin w_col = 2'd0; w_j = 2'd2; end
            4'd3:    begin w_col = 2'd1; w_j = 2'd0; end
            4'd4:    begin w_col = 2'd1; w_j = 2'd1; end
            4'd5:    begin w_col = 2'd1; w_j = 2'd2; end
            4'd6:    begin w_col = 2'd2; w_j = 2'd0; end
            4'd7:    begin w_col = 2'd2; w_j = 2'd1; end
            default: begin w_col = 2'd2; w_j = 2'd2; end
        endcase
        w_ma = '0;
        w_mb = '0;
        if (r_state == B_CROSS) begin
            case (r_s)
                4'd0:    begin w_ma = r_fw[1]; w_mb = r_rt[2]; end
                4'd1:    begin w_ma = r_fw[2]; w_mb = r_rt[1]; end
                4'd2:    begin w_ma = r_fw[2]; w_mb = r_rt[0]; end
                4'd3:    begin w_ma = r_fw[0]; w_mb = r_rt[2]; end
                4'd4:    begin w_ma = r_fw[0]; w_mb = r_rt[1]; end
                4'd5:    begin w_ma = r_fw[1]; w_mb = r_rt[0]; end
                default: ;
            endcase
        end else if (r_state == B_DOT) begin
            w_ma = r_pos[w_j];
            case (w_col)
                2'd0:    w_mb = r_rt[w_j];
                2'd1:    w_mb = r_up[w_j];
                default: w_mb = r_fw[w_j];
            endcase
        end
        w_mul = w_ma * w_mb;
    end

    always_comb begin
        n_state = r_state;
        n_pos   = r_pos;
        n_fw    = r_fw;
        n_rt    = r_rt;
        n_up    = r_up;
        n_ok    = r_ok;
        n_uin   = r_uin;
        n_prod  = r_prod;
        n_s     = r_s;
        n_ptag  = r_ptag;
        n_pv    = r_pv;
        n_dot   = r_dot;
        n_nd    = r_nd;
        n_ebusy = r_ebusy;
        n_ecol  = r_ecol;
        n_eok   = r_eok;
        n_ecv   = r_ecv;

        // column emitter
        if (r_ebusy && !i_stall) begin
            if (r_ecol == 2'd3) n_ebusy = 1'b0;
            else                n_ecol  = r_ecol + 1'b1;
        end

        case (r_state)
            B_IDLE: begin
                if (!i_empty) begin
                    n_pos   = i_job.pos;
                    n_state = B_NF;
                end
            end
            B_NF: begin
                if (w_rsp.done) begin
                    n_fw    = w_rsp.u;
                    n_ok    = w_rsp.ok;
                    n_state = B_NR;
                end
            end
            B_NR: begin
                if (w_rsp.done) begin
                    n_rt    = w_rsp.u;
                    n_ok    = r_ok && w_rsp.ok;
                    n_s     = '0;
                    n_state = B_CROSS;
                end
            end
            B_CROSS: begin
                // up input = cross(forward, right), one product a cycle
                n_s = r_s + 1'b1;
                if (r_s < 4'd6) n_prod = w_mul;
                case (r_s)
                    4'd1: n_uin[0] = r_prod;
                    4'd2: n_uin[0] = r_uin[0] - r_prod;
                    4'd3: n_uin[1] = r_prod;
                    4'd4: n_uin[1] = r_uin[1] - r_prod;
                    4'd5: n_uin[2] = r_prod;
                    4'd6: begin
                        n_uin[2] = r_uin[2] - r_prod;
                        n_state  = B_US;
                    end
                    default: ;
                endcase
            end
            B_US: n_state = B_NU;
            B_NU: begin
                if (w_rsp.done) begin
                    n_up    = w_rsp.u;
                    n_ok    = r_ok && w_rsp.ok;
                    n_s     = '0;
                    n_pv    = 1'b0;
                    n_dot   = '0;
                    n_state = B_DOT;
                end
            end
            B_DOT: begin
                n_s = r_s + 1'b1;
                if (r_s < 4'd9) begin
                    n_prod = w_mul;
                    n_ptag = w_col;
                    n_pv   = 1'b1;
                end else begin
                    n_pv    = 1'b0;
                    n_state = B_FIN;
                end
                if (r_pv) begin
                    case (r_ptag)
                        2'd0:    n_dot[0] = r_dot[0] + r_prod;
                        2'd1:    n_dot[1] = r_dot[1] + r_prod;
                        default: n_dot[2] = r_dot[2] + r_prod;
                    endcase
                end
            end
            B_FIN: begin
                for (int i = 0; i < 3; i++) n_nd[i] = f_neg_dot(r_dot[i]);
                n_state = B_HAND;
            end
            B_HAND: begin
                if (!r_ebusy) begin
                    n_ebusy = 1'b1;
                    n_ecol  = '0;
                    n_eok   = r_ok;
                    for (int i = 0; i < 3; i++) begin
                        n_ecv[0][i] = r_ok ? r_rt[i] : '0;
                        n_ecv[1][i] = r_ok ? r_up[i] : '0;
                        n_ecv[2][i] = r_ok ? r_fw[i] : '0;
                    end
                    n_ecv[0][3] = r_ok ? r_nd[0] : '0;
                    n_ecv[1][3] = r_ok ? r_nd[1] : '0;
                    n_ecv[2][3] = r_ok ? r_nd[2] : '0;
                    n_state = B_IDLE;
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_ebusy <= 1'b0;
            r_ecol  <= '0;
        end else begin
            r_state <= n_state;
            r_ebusy <= n_ebusy;
            r_ecol  <= n_ecol;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos  <= n_pos;
        r_fw   <= n_fw;
        r_rt   <= n_rt;
        r_up   <= n_up;
        r_ok   <= n_ok;
        r_uin  <= n_uin;
        r_prod <= n_prod;
        r_s    <= n_s;
        r_ptag <= n_ptag;
        r_pv   <= n_pv;
        r_dot  <= n_dot;
        r_nd   <= n_nd;
        r_eok  <= n_eok;
        r_ecv  <= n_ecv;
    end

    always_comb begin
        o_valid            = r_ebusy;
        o_out.column_index = r_ecol;
        o_out.degenerate   = !r_eok;
        o_out.last_column  = (r_ecol == 2'd3);
        case (r_ecol)
            2'd0: begin
                o_out.elem0 = r_ecv[0][0];
                o_out.elem1 = r_ecv[0][1];
                o_out.elem2 = r_ecv[0][2];
                o_out.elem3 = r_ecv[0][3];
            end
            2'd1: begin
                o_out.elem0 = r_ecv[1][0];
                o_out.elem1 = r_ecv[1][1];
                o_out.elem2 = r_ecv[1][2];
                o_out.elem3 = r_ecv[1][3];
            end
            2'd2: begin
                o_out.elem0 = r_ecv[2][0];
                o_out.elem1 = r_ecv[2][1];
                o_out.elem2 = r_ecv[2][2];
                o_out.elem3 = r_ecv[2][3];
            end
            default: begin
                o_out.elem0 = '0;
                o_out.elem1 = '0;
                o_out.elem2 = '0;
                o_out.elem3 = 32'd1 << FRAC_BITS;
            end
        endcase
    end

endmodule
